>>> rtl/rsz_pkg.sv
// Shared types and constants of the bicubic resizer.
// Used by rsz_axis and bicubic_image_resize; depends on nothing.
`default_nettype none
package rsz_pkg;
    localparam int MAX_SRC_W   = 256;
    localparam int MAX_SRC_H   = 256;
    localparam int MAX_DST     = 1024;
    localparam int POS_W       = 8;
    localparam int WGT_W       = 18;
    localparam int DIV_W       = 34;
    localparam int FRAC_W      = 16;
    localparam int NUM_TAPS    = 16;

    localparam logic [1:0] CFG_SRC_W = 2'd0;
    localparam logic [1:0] CFG_SRC_H = 2'd1;
    localparam logic [1:0] CFG_DST_W = 2'd2;
    localparam logic [1:0] CFG_DST_H = 2'd3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        AX_IDLE, AX_DIV, AX_SQ, AX_CUBE, AX_WT, AX_DONE
    } t_axis_state;

    typedef enum logic [1:0] {
        ST_IDLE, ST_AXIS, ST_TAPS, ST_HOLD
    } t_rsz_state;

    typedef struct packed {
        logic [3:0][WGT_W-1:0] w;
        logic [3:0][POS_W-1:0] pos;
    } t_axis_res;
endpackage
`default_nettype wire

>>> rtl/rsz_axis.sv
// One axis of the resizer: source position by a bit-serial divider, then
// the four kernel weights and clamped tap positions. Depends on rsz_pkg.
`default_nettype none
module rsz_axis (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [9:0]           i_idx,
    input  wire logic [8:0]           i_src,
    input  wire logic [10:0]          i_dst,
    output logic                      o_done,
    output rsz_pkg::t_axis_res        o_res
);
    rsz_pkg::t_axis_state r_state, n_state;
    logic [rsz_pkg::DIV_W-1:0] r_num, r_quo;
    logic [10:0] r_rem, r_dst;
    logic [8:0]  r_src;
    logic [5:0]  r_cnt;
    logic [31:0] r_f2;
    logic [47:0] r_f3;
    rsz_pkg::t_axis_res r_res;

    logic [11:0] trial;
    logic        qbit;
    logic [15:0] f;
    logic [17:0] p;
    logic signed [53:0] x0, x1, x2, x3, f3s, f2s, f1s;
    logic [18:0] s1, pe, c [4];
    rsz_pkg::t_axis_res n_res;

    assign trial = {r_rem, r_num[rsz_pkg::DIV_W-1]};
    assign qbit  = (trial >= {1'b0, r_dst});
    assign f     = r_quo[rsz_pkg::FRAC_W-1:0];
    assign p     = r_quo[rsz_pkg::DIV_W-1:rsz_pkg::FRAC_W];

    always_comb begin
        f3s = $signed({6'd0, r_f3});
        f2s = $signed({6'd0, r_f2, 16'd0});
        f1s = $signed({6'd0, f, 32'd0});
        x0 = -f3s + 2 * f2s - f1s + (54'sd1 <<< 32);
        x1 = 3 * f3s - 5 * f2s + (54'sd2 <<< 48) + (54'sd1 <<< 32);
        x2 = -3 * f3s + 4 * f2s + f1s + (54'sd1 <<< 32);
        x3 = f3s - f2s + (54'sd1 <<< 32);
        n_res.w[0] = x0[33 +: rsz_pkg::WGT_W];
        n_res.w[1] = x1[33 +: rsz_pkg::WGT_W];
        n_res.w[2] = x2[33 +: rsz_pkg::WGT_W];
        n_res.w[3] = x3[33 +: rsz_pkg::WGT_W];
        s1 = {10'd0, r_src} - 19'd1;
        pe = {1'b0, p};
        c[0] = (pe == 19'd0) ? pe : pe - 19'd1;
        c[1] = pe;
        if (pe >= s1) begin
            c[2] = pe;
            c[3] = pe;
        end else begin
            c[2] = pe + 19'd1;
            c[3] = (pe == s1 - 19'd1) ? pe + 19'd1 : pe + 19'd2;
        end
        for (int i = 0; i < 4; i++) begin
            n_res.pos[i] = (c[i] > s1) ? s1[rsz_pkg::POS_W-1:0]
                                       : c[i][rsz_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsz_pkg::AX_IDLE, rsz_pkg::AX_DONE: begin
                if (i_start) n_state = rsz_pkg::AX_DIV;
            end
            rsz_pkg::AX_DIV: begin
                if (r_cnt == 6'(rsz_pkg::DIV_W - 1)) n_state = rsz_pkg::AX_SQ;
            end
            rsz_pkg::AX_SQ:   n_state = rsz_pkg::AX_CUBE;
            rsz_pkg::AX_CUBE: n_state = rsz_pkg::AX_WT;
            rsz_pkg::AX_WT:   n_state = rsz_pkg::AX_DONE;
            default:          n_state = rsz_pkg::AX_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == rsz_pkg::AX_DONE);
        o_res  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsz_pkg::AX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rsz_pkg::AX_IDLE, rsz_pkg::AX_DONE: begin
                r_num <= {8'(i_idx * i_src) == 8'd0 ? 18'(i_idx * i_src)
                                                    : 18'(i_idx * i_src), 16'd0};
                r_rem <= '0;
                r_cnt <= '0;
                r_dst <= i_dst;
                r_src <= i_src;
            end
            rsz_pkg::AX_DIV: begin
                r_num <= {r_num[rsz_pkg::DIV_W-2:0], 1'b0};
                r_quo <= {r_quo[rsz_pkg::DIV_W-2:0], qbit};
                r_rem <= qbit ? 11'(trial - {1'b0, r_dst}) : trial[10:0];
                r_cnt <= r_cnt + 6'd1;
            end
            rsz_pkg::AX_SQ:   r_f2 <= f * f;
            rsz_pkg::AX_CUBE: r_f3 <= r_f2 * f;
            rsz_pkg::AX_WT:   r_res <= n_res;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/bicubic_image_resize.sv
// Top level of the single-channel bicubic resizer: frame store, tap loop,
// rounding and the stream ports. Depends on rsz_pkg and rsz_axis.
//
// Usage: each input transaction on s_axis is a load (tuser 0) or a compute
// (tuser 1). A load writes one pixel into the 256 x 256 frame store (loads
// outside it are ignored) and gives no result, so loads can be taken on
// every cycle while the block is idle. A compute gives one result
// transaction on m_axis carrying the output row, column and saturated Q17.0
// value (signed, in pixel units), after the bit-serial position divider, the
// kernel weights of both axes and the handoff, the sixteen frame store reads
// through the single read port and the multiply chain, and the load of the
// output register. Items are handled one at a time; s_axis_tready returns as
// the result is loaded. It is high whenever the block is idle, also while a
// finished result waits on m_axis.
// If the receiver stalls, the result holds in the output register and a
// following compute waits after its tap loop until that register is free.
// Configuration writes on the cfg channel are always taken and must only
// happen while the block is idle. Reset restores 256 for all four sizes;
// the frame store is not cleared, and only written entries may be read.
`default_nettype none
module bicubic_image_resize (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // row_index[9:0], column_index[19:10], pixel_value[35:20], zero pad
    input  wire logic [39:0] s_axis_tdata,
    // req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_row[9:0], result_column[19:10], result_value[36:20], zero pad
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    rsz_pkg::t_rsz_state r_state, n_state;
    logic [8:0]  r_src_w, r_src_h;
    logic [10:0] r_dst_w, r_dst_h;
    logic [9:0]  r_row, r_col;
    logic [4:0]  r_k;
    logic [15:0] r_rdata;
    logic signed [35:0] r_wp;
    logic signed [52:0] r_tap;
    logic signed [56:0] r_acc;
    logic        r_v1, r_v2;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic [15:0] mem [0:rsz_pkg::MAX_SRC_W*rsz_pkg::MAX_SRC_H-1];

    logic        in_acc, start, issue, load_out, wr;
    logic        done_y, done_x;
    rsz_pkg::t_axis_res res_y, res_x;
    logic [8:0]  cl_src_w, cl_src_h;
    logic [10:0] cl_dst_w, cl_dst_h;
    logic [15:0] raddr, waddr;
    logic signed [56:0] rnd;
    logic signed [24:0] v;
    logic signed [16:0] sat;

    always_comb begin
        cl_src_w = (r_src_w == 9'd0) ? 9'd1 :
                   (r_src_w > 9'(rsz_pkg::MAX_SRC_W)) ? 9'(rsz_pkg::MAX_SRC_W) : r_src_w;
        cl_src_h = (r_src_h == 9'd0) ? 9'd1 :
                   (r_src_h > 9'(rsz_pkg::MAX_SRC_H)) ? 9'(rsz_pkg::MAX_SRC_H) : r_src_h;
        cl_dst_w = (r_dst_w == 11'd0) ? 11'd1 :
                   (r_dst_w > 11'(rsz_pkg::MAX_DST)) ? 11'(rsz_pkg::MAX_DST) : r_dst_w;
        cl_dst_h = (r_dst_h == 11'd0) ? 11'd1 :
                   (r_dst_h > 11'(rsz_pkg::MAX_DST)) ? 11'(rsz_pkg::MAX_DST) : r_dst_h;
    end

    rsz_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_idx   (s_axis_tdata[9:0]),
        .i_src   (cl_src_h),
        .i_dst   (cl_dst_h),
        .o_done  (done_y),
        .o_res   (res_y)
    );

    rsz_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_idx   (s_axis_tdata[19:10]),
        .i_src   (cl_src_w),
        .i_dst   (cl_dst_w),
        .o_done  (done_x),
        .o_res   (res_x)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsz_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == rsz_pkg::REQ_COMPUTE) begin
                    n_state = rsz_pkg::ST_AXIS;
                end
            end
            rsz_pkg::ST_AXIS: begin
                if (done_y && done_x) n_state = rsz_pkg::ST_TAPS;
            end
            rsz_pkg::ST_TAPS: begin
                if (r_k == 5'(rsz_pkg::NUM_TAPS + 2)) n_state = rsz_pkg::ST_HOLD;
            end
            rsz_pkg::ST_HOLD: begin
                if (!r_out_valid || m_axis_tready) n_state = rsz_pkg::ST_IDLE;
            end
            default: n_state = rsz_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == rsz_pkg::ST_IDLE);
        in_acc   = s_axis_tvalid && s_axis_tready;
        start    = in_acc && (s_axis_tuser == rsz_pkg::REQ_COMPUTE);
        wr       = in_acc && (s_axis_tuser == rsz_pkg::REQ_LOAD) &&
                   (s_axis_tdata[9:8] == 2'd0) && (s_axis_tdata[19:18] == 2'd0);
        issue    = (r_state == rsz_pkg::ST_TAPS) && (r_k < 5'(rsz_pkg::NUM_TAPS));
        load_out = (r_state == rsz_pkg::ST_HOLD) && (!r_out_valid || m_axis_tready);
        o_cfg_ready   = 1'b1;
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_data;
    end

    assign waddr = {s_axis_tdata[7:0], s_axis_tdata[17:10]};
    assign raddr = {res_y.pos[r_k[3:2]], res_x.pos[r_k[1:0]]};

    always_comb begin
        rnd = r_acc + (57'sd1 <<< 31);
        v   = rnd[56:32];
        if (v < -25'sd32768) begin
            sat = -17'sd32768;
        end else if (v > 25'sd65535) begin
            sat = 17'sd65535;
        end else begin
            sat = v[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) mem[waddr] <= s_axis_tdata[35:20];
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_wp  <= $signed(res_y.w[r_k[3:2]]) * $signed(res_x.w[r_k[1:0]]);
        r_tap <= r_wp * $signed({1'b0, r_rdata});
        if (start) begin
            r_row <= s_axis_tdata[9:0];
            r_col <= s_axis_tdata[19:10];
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + 57'(r_tap);
        end
        if (load_out) r_out_data <= {3'd0, sat, r_col, r_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsz_pkg::ST_IDLE;
            r_src_w     <= 9'(rsz_pkg::MAX_SRC_W);
            r_src_h     <= 9'(rsz_pkg::MAX_SRC_H);
            r_dst_w     <= 11'd256;
            r_dst_h     <= 11'd256;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rsz_pkg::CFG_SRC_W: r_src_w <= i_cfg_data[8:0];
                    rsz_pkg::CFG_SRC_H: r_src_h <= i_cfg_data[8:0];
                    rsz_pkg::CFG_DST_W: r_dst_w <= i_cfg_data;
                    rsz_pkg::CFG_DST_H: r_dst_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == rsz_pkg::ST_TAPS) begin
                r_k <= r_k + 5'd1;
            end else begin
                r_k <= '0;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/resize_checker.sv
// Checker for the bicubic resizer: follows the load, compute and register
// transactions, predicts every result pixel and compares it on m_axis.
// Depends on rsz_pkg for the register and request codes.
`default_nettype none
module resize_checker
    import rsz_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    typedef struct {
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [16:0] value;
    } t_pixel_out;

    localparam int DUE_DEPTH = 64;

    logic [15:0] pixel_mem [0:MAX_SRC_W*MAX_SRC_H-1];
    logic [8:0]  src_w, src_h;
    logic [10:0] dst_w, dst_h;
    t_pixel_out  pixels_due [0:DUE_DEPTH-1];
    int          due_wr, due_rd;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q33(longint v);
        return (v + (64'sd1 <<< 32)) >>> 33;
    endfunction

    function automatic void axis_taps(input int unsigned idx, input int unsigned src,
                                      input int unsigned dst, output longint w[4],
                                      output int unsigned pos[4]);
        int unsigned prod, p;
        longint f, f2, f3, f2s, f1s;
        prod = idx * src;
        p = prod / dst;
        f = longint'((64'(prod % dst) << 16) / dst);
        f2 = f * f;
        f3 = f2 * f;
        f2s = f2 <<< 16;
        f1s = f <<< 32;
        w[0] = round_q33(-f3 + 2 * f2s - f1s);
        w[1] = round_q33(3 * f3 - 5 * f2s + (64'sd2 <<< 48));
        w[2] = round_q33(-3 * f3 + 4 * f2s + f1s);
        w[3] = round_q33(f3 - f2s);
        pos[0] = (p == 0) ? p : p - 1;
        pos[1] = p;
        if (p >= src - 1) begin
            pos[2] = p;
            pos[3] = p;
        end else begin
            pos[2] = p + 1;
            pos[3] = (p == src - 2) ? p + 1 : p + 2;
        end
        for (int k = 0; k < 4; k++)
            if (pos[k] > src - 1) pos[k] = src - 1;
    endfunction

    function automatic logic signed [16:0] resample(int unsigned row, int unsigned col);
        longint wy[4], wx[4];
        int unsigned py[4], px[4];
        longint acc, v;
        acc = 0;
        axis_taps(row, clamp_dim(src_h, MAX_SRC_H), clamp_dim(dst_h, MAX_DST), wy, py);
        axis_taps(col, clamp_dim(src_w, MAX_SRC_W), clamp_dim(dst_w, MAX_DST), wx, px);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                acc += longint'(pixel_mem[(py[i] * MAX_SRC_W + px[j]) % 65536])
                       * wy[i] * wx[j];
        v = (acc + (64'sd1 <<< 31)) >>> 32;
        if (v < -32768) v = -32768;
        if (v > 65535) v = 65535;
        return 17'(v);
    endfunction

    assign o_pending = due_wr - due_rd;

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (!i_rst_n) begin
            src_w <= 9'd256;
            src_h <= 9'd256;
            dst_w <= 11'd256;
            dst_h <= 11'd256;
            due_wr = 0;
            due_rd = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SRC_W: src_w <= i_cfg_data[8:0];
                    CFG_SRC_H: src_h <= i_cfg_data[8:0];
                    CFG_DST_W: dst_w <= i_cfg_data;
                    CFG_DST_H: dst_h <= i_cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_LOAD) begin
                    if (s_axis_tdata[9:0] < MAX_SRC_H && s_axis_tdata[19:10] < MAX_SRC_W)
                        pixel_mem[s_axis_tdata[9:0] * MAX_SRC_W + s_axis_tdata[19:10]]
                            = s_axis_tdata[35:20];
                end else begin
                    exp_px.row = s_axis_tdata[9:0];
                    exp_px.col = s_axis_tdata[19:10];
                    exp_px.value = resample(s_axis_tdata[9:0], s_axis_tdata[19:10]);
                    if (due_wr - due_rd >= DUE_DEPTH) begin
                        $error("too many result pixels outstanding");
                        o_errors++;
                    end else begin
                        pixels_due[due_wr % DUE_DEPTH] = exp_px;
                        due_wr++;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_wr == due_rd) begin
                    $error("result transaction with no pixel expected");
                    o_errors++;
                end else begin
                    exp_px = pixels_due[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (m_axis_tdata[9:0] !== exp_px.row) begin
                        $error("result_row: expected %0d, got %0d",
                               exp_px.row, m_axis_tdata[9:0]);
                        o_errors++;
                    end
                    if (m_axis_tdata[19:10] !== exp_px.col) begin
                        $error("result_column: expected %0d, got %0d",
                               exp_px.col, m_axis_tdata[19:10]);
                        o_errors++;
                    end
                    if (m_axis_tdata[36:20] !== exp_px.value) begin
                        $error("result_value: expected %0d, got %0d",
                               exp_px.value, $signed(m_axis_tdata[36:20]));
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/bicubic_image_resize_test.sv
// Top of the resizer testbench: clock, reset, load and compute traffic,
// register phases and the verdict. Depends on rsz_pkg, the resizer and
// resize_checker.
`default_nettype none
module bicubic_image_resize_test;
    import rsz_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;
    int          fail_count;
    int          pixels_pending;

    bit          quiet;
    bit          hold_request;
    bit          written [0:65535];
    int unsigned cur_w, cur_h, cur_tw, cur_th;
    int          items_sent;

    bicubic_image_resize DUT (.*);

    resize_checker checker_inst (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(fail_count), .o_pending(pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("bicubic_image_resize_test NOT OK");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic send(input logic kind, input int unsigned row, input int unsigned col,
                        input int unsigned pix);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {4'd0, pix[15:0], col[9:0], row[9:0]};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        if (kind == REQ_LOAD && row < MAX_SRC_H && col < MAX_SRC_W)
            written[row * MAX_SRC_W + col] = 1'b1;
    endtask

    function automatic int unsigned rand_pixel();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 32768);
    endfunction

    // Loads every unwritten source pixel that a compute of (row, col) can touch, then sends the compute.
    task automatic compute(input int unsigned row, input int unsigned col);
        int unsigned pr, pc, r0, r1, c0, c1;
        pr = row * cur_h / cur_th;
        pc = col * cur_w / cur_tw;
        r0 = (pr == 0) ? 0 : pr - 1;
        c0 = (pc == 0) ? 0 : pc - 1;
        r1 = pr + 2;
        c1 = pc + 2;
        if (r0 > cur_h - 1) r0 = cur_h - 1;
        if (r1 > cur_h - 1) r1 = cur_h - 1;
        if (c0 > cur_w - 1) c0 = cur_w - 1;
        if (c1 > cur_w - 1) c1 = cur_w - 1;
        for (int unsigned r = r0; r <= r1; r++)
            for (int unsigned c = c0; c <= c1; c++)
                if (!written[r * MAX_SRC_W + c]) send(REQ_LOAD, r, c, rand_pixel());
        send(REQ_COMPUTE, row, col, $urandom_range(0, 65535));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[10:0];
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(input int unsigned w, input int unsigned h,
                             input int unsigned tw, input int unsigned th);
        drain();
        write_reg(CFG_SRC_W, w);
        write_reg(CFG_SRC_H, h);
        write_reg(CFG_DST_W, tw);
        write_reg(CFG_DST_H, th);
        @(posedge i_clk);
        cur_w = clamp_dim(w & 9'h1FF, MAX_SRC_W);
        cur_h = clamp_dim(h & 9'h1FF, MAX_SRC_H);
        cur_tw = clamp_dim(tw & 11'h7FF, MAX_DST);
        cur_th = clamp_dim(th & 11'h7FF, MAX_DST);
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: send(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           rand_pixel());
                2: send(REQ_LOAD, $urandom_range(0, cur_h - 1), $urandom_range(0, cur_w - 1),
                        rand_pixel());
                3: compute($urandom_range(0, 1023), $urandom_range(0, 1023));
                default: compute($urandom_range(0, cur_th - 1), $urandom_range(0, cur_tw - 1));
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_LOAD;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SRC_W;
        i_cfg_data = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        cur_w = 256;
        cur_h = 256;
        cur_tw = 256;
        cur_th = 256;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners, beyond-target coordinates, ignored loads, extreme pixels.
        send(REQ_LOAD, 1023, 1023, 16'hFFFF);
        send(REQ_LOAD, 0, 256, 16'h0000);
        send(REQ_LOAD, 0, 0, 32768);
        send(REQ_LOAD, 0, 1, 65535);
        compute(0, 0);
        compute(255, 255);
        compute(1023, 1023);
        compute(254, 1);
        set_sizes(1, 1, 1, 1);
        compute(0, 0);
        compute(1023, 5);
        set_sizes(0, 0, 0, 0);
        compute(0, 0);
        set_sizes(4, 3, 16, 11);
        compute(15, 15);
        compute(6, 9);
        compute(10, 14);
        set_sizes(511, 511, 2047, 2047);
        compute(1023, 1023);
        compute(0, 1023);
        compute(513, 2);

        set_sizes(8, 6, 29, 17);
        random_phase(250);
        hold_request = 1'b1;
        repeat (30) compute($urandom_range(0, cur_th - 1), $urandom_range(0, cur_tw - 1));
        set_sizes(16, 16, 5, 7);
        random_phase(250);
        set_sizes(256, 256, 256, 256);
        random_phase(200);
        set_sizes($urandom_range(1, 12), $urandom_range(1, 12),
                  $urandom_range(1, 40), $urandom_range(1, 40));
        random_phase(250);
        set_sizes(2, 256, 1024, 3);
        random_phase(200);
        set_sizes(7, 9, 7, 9);
        random_phase(150);
        quiet = 1'b1;
        set_sizes(5, 12, 13, 4);
        random_phase(150);

        drain();
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("bicubic_image_resize_test OK");
        end else begin
            $display("bicubic_image_resize_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
